[design/vsp_pkg.sv]
// Shared types and constants of the valley split profile block.
package vsp_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int POS_W       = 6;
    localparam int INT_W       = 32;
    localparam int SUM_W       = 38;
    localparam int ACC_W       = 34;
    localparam int SM_W        = 35;
    localparam int ML_W        = 6;
    localparam int VF_W        = 12;
    localparam int PROD_W      = SM_W + VF_W;
    localparam int CFG_DATA_W  = 12;
    localparam int FRAC_W      = 8;

    localparam logic [ML_W-1:0] MIN_LENGTH_RST    = 6'd2;
    localparam logic [VF_W-1:0] VALLEY_FACTOR_RST = 12'd333;

    typedef enum logic {
        REG_MIN_LENGTH    = 1'b0,
        REG_VALLEY_FACTOR = 1'b1
    } vsp_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SM_SET,
        S_SM_ADDR,
        S_SM_ACC,
        S_SM_DONE,
        S_RMAX,
        S_LMUL,
        S_LCMP,
        S_TAIL,
        S_EMIT_INIT,
        S_EMIT_SEG,
        S_SC_ADDR,
        S_SC_ACC,
        S_PUT,
        S_NONE
    } vsp_state_t;

    typedef struct packed {
        logic [SUM_W-1:0] area_sum;
        logic [INT_W-1:0] apex_intensity;
        logic [POS_W-1:0] apex_pos;
        logic [POS_W-1:0] seg_end;
        logic [POS_W-1:0] seg_start;
        logic             segment_valid;
        logic             truncated;
        logic             last_result;
    } vsp_res_t;

endpackage

[design/vsp_ram.sv]
// Simple dual-port RAM: one write port, one registered read port.
module vsp_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/vsp_engine.sv]
// Sequencer and shared datapath that splits a stored profile into segments.
module vsp_engine #(
    parameter int MAX_LEN = vsp_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [$clog2(MAX_LEN+1)-1:0]  start_n,
    input  logic                          start_ovf,
    input  logic [vsp_pkg::ML_W-1:0]      min_len,
    input  logic [vsp_pkg::VF_W-1:0]      valley_factor,
    output logic                          busy,
    output logic [$clog2(MAX_LEN)-1:0]    smp_raddr,
    input  logic [vsp_pkg::INT_W-1:0]     smp_rdata,
    input  logic                          out_free,
    output logic                          res_put,
    output vsp_pkg::vsp_res_t             res
);
    import vsp_pkg::*;

    localparam int AW   = $clog2(MAX_LEN);
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int CMPW = ((CW > ML_W) ? CW : ML_W) + 2;

    vsp_state_t state_reg, state_next;

    logic [CW-1:0]     n_reg, n_next;
    logic              ovf_reg, ovf_next;
    logic              left_reg, left_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [AW-1:0]     jend_reg, jend_next;
    logic              cnt3_reg, cnt3_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [SM_W-1:0]   sm_reg, sm_next;
    logic [SM_W-1:0]   rm_reg, rm_next;
    logic [SM_W-1:0]   lmax_reg, lmax_next;
    logic [SM_W-1:0]   right_reg, right_next;
    logic [PROD_W-1:0] thr_reg, thr_next;
    logic [CW-1:0]     start_reg, start_next;
    logic [AW-1:0]     lsplit_reg, lsplit_next;
    logic              hsplit_reg, hsplit_next;
    logic [CW-1:0]     nseg_reg, nseg_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [AW-1:0]     a_reg, a_next;
    logic [AW-1:0]     b_reg, b_next;
    logic [AW-1:0]     p_reg, p_next;
    logic [INT_W-1:0]  best_reg, best_next;
    logic [AW-1:0]     apex_reg, apex_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    logic [ML_W-1:0]   ml;
    logic [CMPW-1:0]   ml_c, n_c, i_c, start_c;
    logic              in_range, spacing_ok, l_ok, r_ok, split, seg_ok, pass_done;
    logic              tail_ok, last_seg;
    logic [SM_W-1:0]   left_val, rm_val;

    logic              rm_we;
    logic [AW-1:0]     rm_raddr;
    logic [SM_W-1:0]   rm_rdata;
    logic              sg_we;
    logic [AW-1:0]     sg_waddr;
    logic [2*AW-1:0]   sg_wdata, sg_rdata;

    vsp_ram #(.DW(SM_W), .DEPTH(MAX_LEN)) u_rmax (
        .aclk(aclk), .we(rm_we), .waddr(i_reg), .wdata(rm_val),
        .raddr(rm_raddr), .rdata(rm_rdata)
    );

    vsp_ram #(.DW(2*AW), .DEPTH(MAX_LEN)) u_seglist (
        .aclk(aclk), .we(sg_we), .waddr(sg_waddr), .wdata(sg_wdata),
        .raddr(k_reg), .rdata(sg_rdata)
    );

    assign ml       = (min_len == '0) ? ML_W'(1) : min_len;
    assign ml_c     = CMPW'(ml);
    assign n_c      = CMPW'(n_reg);
    assign i_c      = CMPW'(i_reg);
    assign start_c  = CMPW'(start_reg);
    assign in_range   = i_c >= ml_c - CMPW'(1);
    assign spacing_ok = !hsplit_reg || (i_c >= CMPW'(lsplit_reg) + ml_c);
    assign left_val   = (i_reg == '0) ? sm_reg : lmax_reg;
    assign l_ok       = PROD_W'({left_val, {FRAC_W{1'b0}}}) >= thr_reg;
    assign r_ok       = PROD_W'({right_reg, {FRAC_W{1'b0}}}) >= thr_reg;
    assign split      = in_range && (sm_reg != '0) && l_ok && r_ok && spacing_ok;
    assign seg_ok     = (i_c + CMPW'(1) - start_c) >= ml_c;
    assign pass_done  = i_c == n_c - ml_c - CMPW'(1);
    assign tail_ok    = (start_c < n_c) && ((n_c - start_c) >= ml_c);
    assign rm_val     = (CW'(i_reg) == n_reg - CW'(1)) ? sm_reg :
                        ((sm_reg > rm_reg) ? sm_reg : rm_reg);
    assign last_seg   = (CW'(k_reg) + CW'(1)) == nseg_reg;
    assign busy       = state_reg != S_IDLE;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (CMPW'(start_n) >= (ml_c << 1)) state_next = S_SM_SET;
                    else                               state_next = S_EMIT_INIT;
                end
            end
            S_SM_SET:  state_next = S_SM_ADDR;
            S_SM_ADDR: state_next = S_SM_ACC;
            S_SM_ACC:  state_next = (j_reg == jend_reg) ? S_SM_DONE : S_SM_ADDR;
            S_SM_DONE: state_next = left_reg ? S_LMUL : S_RMAX;
            S_RMAX:    state_next = S_SM_SET;
            S_LMUL:    state_next = S_LCMP;
            S_LCMP:    state_next = pass_done ? S_TAIL : S_SM_SET;
            S_TAIL:    state_next = S_EMIT_INIT;
            S_EMIT_INIT: state_next = (nseg_reg == '0) ? S_NONE : S_EMIT_SEG;
            S_EMIT_SEG:  state_next = S_SC_ADDR;
            S_SC_ADDR:   state_next = S_SC_ACC;
            S_SC_ACC:    state_next = (p_reg == b_reg) ? S_PUT : S_SC_ADDR;
            S_PUT: begin
                if (out_free) state_next = last_seg ? S_IDLE : S_EMIT_INIT;
            end
            S_NONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_next      = n_reg;
        ovf_next    = ovf_reg;
        left_next   = left_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        jend_next   = jend_reg;
        cnt3_next   = cnt3_reg;
        acc_next    = acc_reg;
        sm_next     = sm_reg;
        rm_next     = rm_reg;
        lmax_next   = lmax_reg;
        right_next  = right_reg;
        thr_next    = thr_reg;
        start_next  = start_reg;
        lsplit_next = lsplit_reg;
        hsplit_next = hsplit_reg;
        nseg_next   = nseg_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        p_next      = p_reg;
        best_next   = best_reg;
        apex_next   = apex_reg;
        sum_next    = sum_reg;
        rm_we       = 1'b0;
        rm_raddr    = AW'(i_reg + AW'(1));
        sg_we       = 1'b0;
        sg_waddr    = AW'(nseg_reg);
        sg_wdata    = {AW'(start_reg), i_reg};
        smp_raddr   = (state_reg == S_SC_ADDR) ? p_reg : j_reg;
        res_put     = 1'b0;
        res         = '0;
        res.truncated = ovf_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    n_next      = start_n;
                    ovf_next    = start_ovf;
                    left_next   = 1'b0;
                    i_next      = AW'(start_n - CW'(1));
                    start_next  = '0;
                    hsplit_next = 1'b0;
                    lmax_next   = '0;
                    k_next      = '0;
                    nseg_next   = '0;
                    if ((CMPW'(start_n) < (ml_c << 1)) && (CMPW'(start_n) >= ml_c)) begin
                        sg_we     = 1'b1;
                        sg_waddr  = '0;
                        sg_wdata  = {AW'(0), AW'(start_n - CW'(1))};
                        nseg_next = CW'(1);
                    end
                end
            end
            S_SM_SET: begin
                j_next    = (i_reg == '0) ? '0 : AW'(i_reg - AW'(1));
                jend_next = (i_c + CMPW'(1) < n_c) ? AW'(i_reg + AW'(1)) : i_reg;
                cnt3_next = (i_reg != '0) && (i_c + CMPW'(1) < n_c);
                acc_next  = '0;
            end
            S_SM_ACC: begin
                acc_next = acc_reg + ACC_W'(smp_rdata);
                j_next   = AW'(j_reg + AW'(1));
            end
            S_SM_DONE: begin
                // Hold the smoothed value as six times the window mean.
                sm_next = cnt3_reg ? {acc_reg, 1'b0} : SM_W'(acc_reg) + {acc_reg, 1'b0};
            end
            S_RMAX: begin
                rm_we   = 1'b1;
                rm_next = rm_val;
                if (i_reg == '0) left_next = 1'b1;
                else             i_next    = AW'(i_reg - AW'(1));
            end
            S_LMUL: begin
                thr_next   = PROD_W'(valley_factor) * PROD_W'(sm_reg);
                right_next = rm_rdata;
            end
            S_LCMP: begin
                if (split) begin
                    if (seg_ok) begin
                        sg_we     = 1'b1;
                        nseg_next = CW'(nseg_reg + CW'(1));
                    end
                    start_next  = CW'(i_c + CMPW'(1));
                    lsplit_next = i_reg;
                    hsplit_next = 1'b1;
                end
                if (sm_reg > lmax_reg) lmax_next = sm_reg;
                i_next = AW'(i_reg + AW'(1));
            end
            S_TAIL: begin
                sg_wdata = {AW'(start_reg), AW'(n_reg - CW'(1))};
                if (tail_ok) begin
                    sg_we     = 1'b1;
                    nseg_next = CW'(nseg_reg + CW'(1));
                end
            end
            S_EMIT_SEG: begin
                a_next    = sg_rdata[2*AW-1:AW];
                b_next    = sg_rdata[AW-1:0];
                p_next    = sg_rdata[2*AW-1:AW];
                apex_next = sg_rdata[2*AW-1:AW];
                best_next = '0;
                sum_next  = '0;
            end
            S_SC_ACC: begin
                if (smp_rdata > best_reg) begin
                    best_next = smp_rdata;
                    apex_next = p_reg;
                end
                sum_next = sum_reg + SUM_W'(smp_rdata);
                p_next   = AW'(p_reg + AW'(1));
            end
            S_PUT: begin
                res.seg_start      = POS_W'(a_reg);
                res.seg_end        = POS_W'(b_reg);
                res.apex_pos       = POS_W'(apex_reg);
                res.apex_intensity = best_reg;
                res.area_sum       = sum_reg;
                res.segment_valid  = 1'b1;
                res.last_result    = last_seg;
                if (out_free) begin
                    res_put = 1'b1;
                    k_next  = AW'(k_reg + AW'(1));
                end
            end
            S_NONE: begin
                res.last_result = 1'b1;
                res_put         = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        ovf_reg    <= ovf_next;
        left_reg   <= left_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        jend_reg   <= jend_next;
        cnt3_reg   <= cnt3_next;
        acc_reg    <= acc_next;
        sm_reg     <= sm_next;
        rm_reg     <= rm_next;
        lmax_reg   <= lmax_next;
        right_reg  <= right_next;
        thr_reg    <= thr_next;
        start_reg  <= start_next;
        lsplit_reg <= lsplit_next;
        hsplit_reg <= hsplit_next;
        nseg_reg   <= nseg_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        p_reg      <= p_next;
        best_reg   <= best_next;
        apex_reg   <= apex_next;
        sum_reg    <= sum_next;
    end
endmodule

[design/valley_split_profile.sv]
// Valley split profile: loads an elution profile and reports one result per segment, or a
// single empty result when there is none. Samples stream in at one per cycle with no gaps
// needed. After the sample marked tlast the block stops taking samples and works through
// the stored profile with one sequencer and one read port on the sample memory: when the
// profile holds at least twice the minimum segment length, a backward pass builds
// right-side maxima of the smoothed profile and a forward pass tests split points; every
// reported segment is then scanned sample by sample, and is held while the output is
// stalled. Shorter profiles skip both passes. s_tready rises again once the final result
// sits in the output register, so the next profile can load while that result waits to be
// taken.
module valley_split_profile #(
    parameter int MAX_LEN = vsp_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] intensity
    input  logic                          s_tlast,   // last_sample
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [87:0]                   m_tdata,   // seg_start, seg_end, apex_pos,
                                                     // apex_intensity, area_sum
    output logic [1:0]                    m_tuser,   // segment_valid, truncated
    output logic                          m_tlast,   // last_result
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  vsp_pkg::vsp_reg_t             cfg_index,
    input  logic [vsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vsp_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [ML_W-1:0] min_len_reg;
    logic [VF_W-1:0] valley_factor_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            mvalid_reg, mvalid_next;
    vsp_res_t        out_reg, out_next;

    logic            s_acc, full, busy, start, out_free, res_put;
    logic [CW-1:0]   start_n;
    logic            start_ovf;
    logic [AW-1:0]   smp_raddr;
    logic [INT_W-1:0] smp_rdata;
    vsp_res_t        res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign s_acc     = s_tvalid && s_tready;
    assign full      = count_reg == CW'(MAX_LEN);
    assign start     = s_acc && s_tlast;
    assign start_n   = full ? count_reg : CW'(count_reg + CW'(1));
    assign start_ovf = ovf_reg || full;
    assign out_free  = !mvalid_reg || m_tready;

    vsp_ram #(.DW(INT_W), .DEPTH(MAX_LEN)) u_samples (
        .aclk(aclk), .we(s_acc && !full), .waddr(AW'(count_reg)), .wdata(s_tdata),
        .raddr(smp_raddr), .rdata(smp_rdata)
    );

    vsp_engine #(.MAX_LEN(MAX_LEN)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .start(start), .start_n(start_n), .start_ovf(start_ovf),
        .min_len(min_len_reg), .valley_factor(valley_factor_reg),
        .busy(busy), .smp_raddr(smp_raddr), .smp_rdata(smp_rdata),
        .out_free(out_free), .res_put(res_put), .res(res)
    );

    always_comb begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        mvalid_next = mvalid_reg;
        out_next    = out_reg;
        if (s_acc) begin
            if (s_tlast) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = CW'(count_reg + CW'(1));
            end
        end
        if (res_put) begin
            mvalid_next = 1'b1;
            out_next    = res;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg       <= MIN_LENGTH_RST;
            valley_factor_reg <= VALLEY_FACTOR_RST;
            count_reg         <= '0;
            ovf_reg           <= 1'b0;
            mvalid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_LENGTH:    min_len_reg       <= cfg_data[ML_W-1:0];
                    REG_VALLEY_FACTOR: valley_factor_reg <= cfg_data[VF_W-1:0];
                    default: ;
                endcase
            end
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {out_reg.area_sum, out_reg.apex_intensity, out_reg.apex_pos,
                       out_reg.seg_end, out_reg.seg_start};
    assign m_tuser  = {out_reg.truncated, out_reg.segment_valid};
    assign m_tlast  = out_reg.last_result;
endmodule

[design/vsp_checker.sv]
// Port-level checks for the valley split profile block, bound to the top level.
module vsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("sample taken right after profile end");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 88'd0))
        else $error("empty result malformed");

    a_apex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[5:0] <= m_tdata[17:12]) && (m_tdata[17:12] <= m_tdata[11:6]))
        else $error("apex outside segment");
endmodule

bind valley_split_profile vsp_checker u_vsp_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
);

[dv/valley_split_profile_tb.sv]
// Testbench for the valley split profile block: directed and random profiles checked against a predictor.
`timescale 1ns / 100ps

module valley_split_profile_tb;
    import vsp_pkg::*;

    typedef struct packed {
        logic [5:0]  seg_start;
        logic [5:0]  seg_end;
        logic [5:0]  apex_pos;
        logic [31:0] apex_intensity;
        logic [37:0] area_sum;
        logic        segment_valid;
        logic        truncated;
        logic        last_result;
    } segment_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    vsp_reg_t    cfg_index;
    logic [11:0] cfg_data;

    valley_split_profile u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [5:0]  pred_min_len;
    logic [11:0] pred_factor;
    logic [31:0] profile_buf [64];
    int unsigned profile_len;
    bit          profile_overflow;

    segment_t    pending_segments[$];
    int          error_count = 0;
    int          sample_total;
    int          result_total = 0;
    int          profile_total;
    int          idle_cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_off_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void queue_segment(int unsigned a, int unsigned b, bit last);
        segment_t seg;
        logic [37:0] sum;
        logic [31:0] best;
        int unsigned apex;
        sum = '0;
        best = '0;
        apex = a;
        for (int unsigned p = a; p <= b; p++) begin
            if (profile_buf[p] > best) begin
                best = profile_buf[p];
                apex = p;
            end
            sum += profile_buf[p];
        end
        seg.seg_start      = a[5:0];
        seg.seg_end        = b[5:0];
        seg.apex_pos       = apex[5:0];
        seg.apex_intensity = best;
        seg.area_sum       = sum;
        seg.segment_valid  = 1'b1;
        seg.truncated      = profile_overflow;
        seg.last_result    = last;
        pending_segments.insert(pending_segments.size(), seg);
    endfunction

    // cut the stored profile into segments and queue the expected results
    function automatic void predict_segments();
        int unsigned n, ml, ns, start, nseg;
        logic [34:0] smooth [64];
        logic [34:0] suffix_max [64];
        logic [34:0] lmax, v, left;
        logic [46:0] thr;
        int unsigned splits [64];
        int unsigned seg_a [64], seg_b [64];
        segment_t none_seg;
        n = profile_len;
        ml = (pred_min_len == 0) ? 1 : pred_min_len;
        nseg = 0;
        ns = 0;
        start = 0;
        if (n >= 2 * ml) begin
            for (int unsigned i = 0; i < n; i++) begin
                logic [34:0] acc;
                int unsigned lo, hi;
                lo = (i >= 1) ? i - 1 : 0;
                hi = (i + 2 < n) ? i + 2 : n;
                acc = '0;
                for (int unsigned j = lo; j < hi; j++) acc += profile_buf[j];
                smooth[i] = (hi - lo == 3) ? acc * 2 : acc * 3;
            end
            suffix_max[n-1] = smooth[n-1];
            for (int unsigned i = n - 1; i > 0; i--)
                suffix_max[i-1] = (smooth[i-1] > suffix_max[i]) ? smooth[i-1] : suffix_max[i];
            lmax = '0;
            for (int unsigned i = 0; i + 1 < ml; i++)
                if (smooth[i] > lmax) lmax = smooth[i];
            for (int unsigned i = ml - 1; i < n - ml; i++) begin
                v = smooth[i];
                if (v != 0) begin
                    left = (i == 0) ? v : lmax;
                    thr = pred_factor * v;
                    if ({left, 8'b0} >= {8'b0, thr} && {suffix_max[i+1], 8'b0} >= {8'b0, thr}
                            && (ns == 0 || i >= splits[ns-1] + ml)) begin
                        splits[ns] = i;
                        ns++;
                    end
                end
                if (v > lmax) lmax = v;
            end
            for (int unsigned s = 0; s < ns; s++) begin
                if (splits[s] + 1 - start >= ml) begin
                    seg_a[nseg] = start;
                    seg_b[nseg] = splits[s];
                    nseg++;
                end
                start = splits[s] + 1;
            end
            if (start < n && n - start >= ml) begin
                seg_a[nseg] = start;
                seg_b[nseg] = n - 1;
                nseg++;
            end
        end else if (n >= ml && n > 0) begin
            seg_a[0] = 0;
            seg_b[0] = n - 1;
            nseg = 1;
        end
        if (nseg == 0) begin
            none_seg = '0;
            none_seg.truncated = profile_overflow;
            none_seg.last_result = 1'b1;
            pending_segments.insert(pending_segments.size(), none_seg);
        end else begin
            for (int unsigned k = 0; k < nseg; k++)
                queue_segment(seg_a[k], seg_b[k], k + 1 == nseg);
        end
    endfunction

    function automatic void absorb_sample(logic [31:0] value, logic last);
        if (profile_len < 64) begin
            profile_buf[profile_len] = value;
            profile_len++;
        end else begin
            profile_overflow = 1'b1;
        end
        if (last) begin
            predict_segments();
            profile_len = 0;
            profile_overflow = 1'b0;
            profile_total++;
        end
    endfunction

    // s_tvalid stays high after a transaction until the next idle gap or drain
    task automatic send_sample(logic [31:0] value, logic last);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        absorb_sample(value, last);
        sample_total++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_segments.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(vsp_reg_t idx, logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_MIN_LENGTH) pred_min_len = value[5:0];
        else pred_factor = value;
    endtask

    task automatic set_config(logic [11:0] ml, logic [11:0] vf);
        wait_drained();
        write_reg(REG_MIN_LENGTH, ml);
        write_reg(REG_VALLEY_FACTOR, vf);
        cfg_valid <= 1'b0;
    endtask

    // a dip at a random position with the profile rising towards both ends, random content
    task automatic send_valley_profile(int unsigned len);
        int unsigned dip;
        logic [31:0] peak;
        dip = $urandom_range(len - 1, 0);
        peak = $urandom_range(32'hFFFF, 16);
        for (int unsigned i = 0; i < len; i++) begin
            logic [31:0] value;
            int unsigned gap;
            gap = (i > dip) ? i - dip : dip - i;
            value = peak * gap / len + $urandom_range(3, 0);
            if ($urandom_range(9, 0) == 0) value = $urandom();
            send_sample(value, i == len - 1);
        end
    endtask

    task automatic test_directed();
        set_config(12'd2, 12'd333);
        send_sample(32'd0, 1'b1);                       // single zero: too short
        send_sample(32'hFFFF_FFFF, 1'b0);               // short profile kept whole
        send_sample(32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 4; i++) send_sample(32'd0, i == 3);  // all zero
        send_sample(32'd1, 1'b0);                       // low sample at position 0, before the first candidate
        for (int i = 0; i < 5; i++) send_sample(32'd9, i == 4);
        // valley in the middle
        send_sample(32'd100, 1'b0); send_sample(32'd90, 1'b0); send_sample(32'd1, 1'b0);
        send_sample(32'd1, 1'b0); send_sample(32'd80, 1'b0); send_sample(32'd100, 1'b1);
        set_config(12'd1, 12'd0);
        for (int i = 0; i < 6; i++) send_sample(32'hAAAA_5555 ^ i, i == 5);
        set_config(12'd0, 12'd4095);
        send_sample(32'h5555_AAAA, 1'b0); send_sample(32'd7, 1'b1);
    endtask

    task automatic test_overflow();
        set_config(12'd3, 12'd256);
        for (int i = 0; i < 66; i++) send_sample($urandom_range(200, 0), i == 65);
        set_config(12'd32, 12'd333);
        for (int i = 0; i < 64; i++) send_sample($urandom(), i == 63);
    endtask

    task automatic test_random(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            int unsigned len;
            len = ($urandom_range(15, 0) == 0) ? $urandom_range(64, 40) : $urandom_range(14, 1);
            if ($urandom_range(4, 0) == 0) begin
                for (int unsigned i = 0; i < len; i++) send_sample($urandom(), i == len - 1);
            end else begin
                send_valley_profile(len);
            end
            sent += len;
        end
    endtask

    task automatic test_random_configs();
        set_config(12'd1, 12'd256);
        test_random(25);
        set_config(12'd4, 12'd2000);
        test_random(25);
        set_config(12'($urandom_range(6, 1)), 12'($urandom_range(4095, 256)));
        test_random(25);
    endtask

    task automatic test_backpressure();
        set_config(12'd2, 12'd300);
        hold_req++;
        for (int p = 0; p < 6; p++) send_valley_profile(6);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            segment_t got, exp_seg;
            got.seg_start      = m_tdata[5:0];
            got.seg_end        = m_tdata[11:6];
            got.apex_pos       = m_tdata[17:12];
            got.apex_intensity = m_tdata[49:18];
            got.area_sum       = m_tdata[87:50];
            got.segment_valid  = m_tuser[0];
            got.truncated      = m_tuser[1];
            got.last_result    = m_tlast;
            result_total++;
            if (pending_segments.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
            end else begin
                exp_seg = pending_segments.pop_front();
                if (got !== exp_seg) begin
                    error_count++;
                    $display("%0t: mismatch expected %p actual %p", $time, exp_seg, got);
                end
            end
        end
    end

    // receiver stalls, with a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off_cycles <= 1500;
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || hold_off_cycles > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_LENGTH;
        cfg_data = '0;
        pred_min_len = 6'd2;
        pred_factor = 12'd333;
        profile_len = 0;
        profile_overflow = 1'b0;
        sample_total = 0;
        profile_total = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overflow();
        test_random_configs();
        send_idle_pct = 62;
        test_random(20);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        test_random(20);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        test_random(15);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        wait_drained();

        $display("Covered %0d samples in %0d profiles, %0d results checked,", sample_total,
                 profile_total, result_total);
        $display("over several register settings, idle patterns and one long output hold-off.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
